>>> hdl/lpfs_pkg.sv
package lpfs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam logic [WORD_W-1:0] HDR_BYTES = 32'd4;
    localparam logic [WORD_W-1:0] ID_END    = 32'd8;

    typedef struct packed {
        logic                frame_malformed;
        logic                frame_last;
        logic [WORD_W-1:0]   message_id;
        logic [WORD_W-1:0]   declared_length;
        logic [WORD_W-1:0]   frame_offset;
        logic [BYTE_W-1:0]   out_byte;
    } t_item;

endpackage

>>> hdl/length_prefixed_frame_splitter_core.sv
// Cuts a byte stream into frames that each open with a 4-byte big-endian
// length (counting the whole frame) followed by a 4-byte big-endian message
// id. Every input item is one byte and yields one output item carrying the
// byte, its offset in the frame, the declared length, the message id, tlast
// on the closing byte, and tuser on the closing byte of a frame whose length
// is below 8, which closes at its fourth byte. The block takes one byte per
// clock cycle while s_tready is high; the frame state loop in the front
// stage settles each byte in that cycle, and a queue of QUEUE_DEPTH items
// plus one output register lets input and output stall independently.
// From input to output each byte passes through the queue and then the
// output register.
module length_prefixed_frame_splitter_core
    import lpfs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [BYTE_W-1:0]          s_tdata,   // byte_value
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_byte, frame_offset, declared_length, message_id
    output logic [BYTE_W+3*WORD_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser    // frame_malformed
);

    logic  push;
    logic  space;
    logic  avail;
    logic  pop;
    t_item front_item;
    t_item head_item;

    lpfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_byte  (s_tdata),
        .i_space (space),
        .o_ready (s_tready),
        .o_push  (push),
        .o_item  (front_item)
    );

    lpfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_space (space),
        .i_pop   (pop),
        .o_avail (avail),
        .o_item  (head_item)
    );

    lpfs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (avail),
        .i_item     (head_item),
        .o_pop      (pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

endmodule

>>> hdl/lpfs_front.sv
module lpfs_front
    import lpfs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_space,
    output logic              o_ready,
    output logic              o_push,
    output t_item             o_item
);

    logic [WORD_W-1:0] r_offset;
    logic [WORD_W-1:0] r_length;
    logic [WORD_W-1:0] r_id;
    logic [WORD_W-1:0] n_length;
    logic [WORD_W-1:0] n_id;
    logic [WORD_W:0]   next_count;
    logic              take;
    logic              last;
    logic              bad;

    assign o_ready = i_space;
    assign take    = i_valid && i_space;
    assign o_push  = take;
    assign next_count = {1'b0, r_offset} + {{WORD_W{1'b0}}, 1'b1};

    always_comb begin
        n_length = r_length;
        n_id     = r_id;
        if (r_offset < HDR_BYTES) begin
            if (r_offset == '0) begin
                n_length = {{(WORD_W-BYTE_W){1'b0}}, i_byte};
            end else begin
                n_length = {r_length[WORD_W-BYTE_W-1:0], i_byte};
            end
        end else if (r_offset < ID_END) begin
            if (r_offset == HDR_BYTES) begin
                n_id = {{(WORD_W-BYTE_W){1'b0}}, i_byte};
            end else begin
                n_id = {r_id[WORD_W-BYTE_W-1:0], i_byte};
            end
        end
        bad  = 1'b0;
        last = 1'b0;
        if (r_offset == HDR_BYTES - 32'd1 && n_length < ID_END) begin
            bad  = 1'b1;
            last = 1'b1;
        end else if (r_offset >= HDR_BYTES && next_count >= {1'b0, n_length}) begin
            last = 1'b1;
        end
    end

    always_comb begin
        o_item.out_byte        = i_byte;
        o_item.frame_offset    = r_offset;
        o_item.declared_length = n_length;
        o_item.message_id      = n_id;
        o_item.frame_last      = last;
        o_item.frame_malformed = bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_length <= '0;
            r_id     <= '0;
        end else if (take) begin
            if (last) begin
                r_offset <= '0;
                r_length <= '0;
                r_id     <= '0;
            end else begin
                r_offset <= next_count[WORD_W-1:0];
                r_length <= n_length;
                r_id     <= n_id;
            end
        end
    end

endmodule

>>> hdl/lpfs_queue.sv
module lpfs_queue
    import lpfs_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_space,
    input  logic  i_pop,
    output logic  o_avail,
    output t_item o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_space = (r_count != FULL_CNT);
    assign o_avail = (r_count != '0);
    assign o_item  = r_slot[r_rd];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/lpfs_back.sv
module lpfs_back
    import lpfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_avail,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [BYTE_W+3*WORD_W-1:0] o_m_tdata,
    output logic                  o_m_tlast,
    output logic                  o_m_tuser
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign load  = i_avail && (!r_valid || i_m_tready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_item.message_id, r_item.declared_length,
                         r_item.frame_offset, r_item.out_byte};
    assign o_m_tlast  = r_item.frame_last;
    assign o_m_tuser  = r_item.frame_malformed;

endmodule
